/* rtl/cct_pkg.sv */
package cct_pkg;

    localparam int POSITION_BITS = 32;
    localparam int LENGTH_BITS   = 16;
    localparam int KEYWORD_CHARS = 8;
    localparam int KIND_BITS     = 5;
    localparam int MODE_BITS     = 4;
    localparam int WINDOW_BITS   = 8 * KEYWORD_CHARS;
    localparam int KW_IDX_BITS   = $clog2(KEYWORD_CHARS);

    localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd0;
    localparam logic [KIND_BITS-1:0] K_KEYWORD = 5'd1;
    localparam logic [KIND_BITS-1:0] K_INTEGER = 5'd2;
    localparam logic [KIND_BITS-1:0] K_DOUBLE  = 5'd3;
    localparam logic [KIND_BITS-1:0] K_FLOAT   = 5'd4;
    localparam logic [KIND_BITS-1:0] K_STRING  = 5'd5;
    localparam logic [KIND_BITS-1:0] K_INVALID = 5'd6;
    localparam logic [KIND_BITS-1:0] K_PUNCT0  = 5'd7;

    localparam logic [MODE_BITS-1:0] M_IDLE    = 4'd0;
    localparam logic [MODE_BITS-1:0] M_IDENT   = 4'd1;
    localparam logic [MODE_BITS-1:0] M_INT     = 4'd2;
    localparam logic [MODE_BITS-1:0] M_FRAC    = 4'd3;
    localparam logic [MODE_BITS-1:0] M_EXPSIGN = 4'd4;
    localparam logic [MODE_BITS-1:0] M_EXP     = 4'd5;
    localparam logic [MODE_BITS-1:0] M_STRING  = 4'd6;
    localparam logic [MODE_BITS-1:0] M_ESCAPE  = 4'd7;
    localparam logic [MODE_BITS-1:0] M_INVALID = 4'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_BITS  = $clog2(QUEUE_DEPTH);
    localparam logic [QUEUE_BITS:0] QUEUE_FULL = (QUEUE_BITS+1)'(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] text_char;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0]     token_kind;
        logic [POSITION_BITS-1:0] token_start;
        logic [LENGTH_BITS-1:0]   token_len;
        logic                     last_in_run;
    } out_item_t;

    // What the front end decided for one character.
    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic       is_space;
        logic       is_digit;
        logic       is_alpha;
        logic       is_word;
        logic       is_punct;
        logic [3:0] punct_idx;
    } class_t;

    function automatic logic is_space_f(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit_f(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha_f(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic [4:0] punct_f(input logic [7:0] c);
        logic [4:0] r;
        begin
            case (c)
                8'h2b: r = 5'h10;
                8'h2d: r = 5'h11;
                8'h2a: r = 5'h12;
                8'h2f: r = 5'h13;
                8'h28: r = 5'h14;
                8'h29: r = 5'h15;
                8'h7b: r = 5'h16;
                8'h7d: r = 5'h17;
                8'h3c: r = 5'h18;
                8'h3e: r = 5'h19;
                8'h5b: r = 5'h1a;
                8'h5d: r = 5'h1b;
                8'h2c: r = 5'h1c;
                8'h3b: r = 5'h1d;
                default: r = 5'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [WINDOW_BITS-1:0] kw_f(input string s);
        logic [WINDOW_BITS-1:0] w;
        begin
            w = '0;
            for (int i = 0; i < s.len(); i++)
            begin
                w[8*i +: 8] = s[i];
            end
            return w;
        end
    endfunction

    function automatic logic is_keyword_f(input logic [WINDOW_BITS-1:0] w);
        logic k;
        begin
            k = (w == kw_f("char"))   || (w == kw_f("int"))    || (w == kw_f("double"))
             || (w == kw_f("float"))  || (w == kw_f("struct")) || (w == kw_f("enum"))
             || (w == kw_f("void"))   || (w == kw_f("short"))  || (w == kw_f("long"))
             || (w == kw_f("const"))  || (w == kw_f("static")) || (w == kw_f("if"))
             || (w == kw_f("else"))   || (w == kw_f("for"))    || (w == kw_f("while"))
             || (w == kw_f("break"))  || (w == kw_f("continue")) || (w == kw_f("return"));
            return k;
        end
    endfunction

endpackage

/* rtl/cct_front.sv */
module cct_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              stall,
    input  cct_pkg::in_item_t in_item,
    output logic              q_valid,
    input  logic              q_stall,
    output cct_pkg::class_t   q_item
);

    cct_pkg::class_t cls;
    cct_pkg::class_t slot_reg [cct_pkg::QUEUE_DEPTH];
    logic [cct_pkg::QUEUE_BITS:0]   count_reg;
    logic [cct_pkg::QUEUE_BITS:0]   count_next;
    logic [cct_pkg::QUEUE_BITS-1:0] rd_reg;
    logic [cct_pkg::QUEUE_BITS-1:0] wr_reg;
    logic [4:0] pv;
    logic push;
    logic pop;

    always_comb
    begin
        pv = cct_pkg::punct_f(in_item.text_char);
        cls.ch        = in_item.text_char;
        cls.eot       = in_item.end_of_text;
        cls.is_space  = cct_pkg::is_space_f(in_item.text_char);
        cls.is_digit  = cct_pkg::is_digit_f(in_item.text_char);
        cls.is_alpha  = cct_pkg::is_alpha_f(in_item.text_char);
        cls.is_word   = cls.is_alpha || cls.is_digit || (in_item.text_char == 8'h5f);
        cls.is_punct  = pv[4];
        cls.punct_idx = pv[3:0];
    end

    assign stall   = (count_reg == cct_pkg::QUEUE_FULL);
    assign push    = valid && !stall;
    assign q_valid = (count_reg != '0);
    assign pop     = q_valid && !q_stall;
    assign q_item  = slot_reg[rd_reg];
    assign count_next = count_reg + {{cct_pkg::QUEUE_BITS{1'b0}}, push}
                                  - {{cct_pkg::QUEUE_BITS{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= '0;
            wr_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= cct_pkg::QUEUE_FULL)
        else $error("Queue count out of range.");
    assert property (@(posedge clk) disable iff (!rst_n) (push && !pop) |=> count_reg != '0)
        else $error("Queue lost a request.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_reg == wr_reg))
        else $error("Empty queue with pointers apart.");

endmodule

/* rtl/cct_back.sv */
module cct_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_stall,
    input  cct_pkg::class_t    q_item,
    output logic               valid,
    input  logic               stall,
    output cct_pkg::out_item_t out_item
);

    logic [cct_pkg::MODE_BITS-1:0]     mode_reg, mode_next;
    logic [cct_pkg::POSITION_BITS-1:0] pos_reg, pos_next;
    logic [cct_pkg::POSITION_BITS-1:0] start_reg, start_next;
    logic [cct_pkg::LENGTH_BITS-1:0]   len_reg, len_next;
    logic [cct_pkg::WINDOW_BITS-1:0]   win_reg, win_next;
    logic                              dig_reg, dig_next;

    // Result one goes out first; a second result waits in the pending slot.
    logic              out_valid_reg, pend_valid_reg;
    cct_pkg::out_item_t out_reg, pend_reg;

    logic               n1, n2;
    cct_pkg::out_item_t r1, r2;
    logic               take;
    logic               can_take;
    logic               absorbed;
    logic               emit_pend;
    logic [cct_pkg::KIND_BITS-1:0] emit_kind;
    logic [cct_pkg::KIND_BITS-1:0] pend_kind;
    logic [cct_pkg::LENGTH_BITS-1:0] len_sat;
    logic                          kw_slot;
    logic [cct_pkg::MODE_BITS-1:0] m;
    logic [7:0]                    c;
    logic                          out_free;

    assign out_free = !out_valid_reg || !stall;
    assign can_take = out_free && !pend_valid_reg;
    assign take     = q_valid && can_take;
    assign q_stall  = !can_take;

    always_comb
    begin
        m = (mode_reg > cct_pkg::M_INVALID) ? cct_pkg::M_IDLE : mode_reg;
        c = q_item.ch;
        if (len_reg < cct_pkg::LENGTH_BITS'(cct_pkg::KEYWORD_CHARS + 1))
        begin
            pend_kind = cct_pkg::is_keyword_f(win_reg) ? cct_pkg::K_KEYWORD
                                                       : cct_pkg::K_IDENT;
        end
        else
        begin
            pend_kind = cct_pkg::K_IDENT;
        end
        case (m)
            cct_pkg::M_IDENT: ;
            cct_pkg::M_INT:   pend_kind = cct_pkg::K_INTEGER;
            cct_pkg::M_FRAC,
            cct_pkg::M_EXP:   pend_kind = dig_reg ? cct_pkg::K_DOUBLE : cct_pkg::K_INVALID;
            default:          pend_kind = cct_pkg::K_INVALID;
        endcase
    end

    always_comb
    begin
        mode_next  = m;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        win_next   = win_reg;
        dig_next   = dig_reg;
        n1 = 1'b0;
        n2 = 1'b0;
        r1 = '0;
        r2 = '0;
        absorbed  = 1'b0;
        emit_pend = 1'b0;
        emit_kind = pend_kind;
        kw_slot   = (len_reg < cct_pkg::LENGTH_BITS'(cct_pkg::KEYWORD_CHARS));
        len_sat   = (len_reg == '1) ? len_reg : len_reg + 1'b1;

        if (q_item.eot)
        begin
            if (m != cct_pkg::M_IDLE)
            begin
                n1 = 1'b1;
                r1.token_kind  = pend_kind;
                r1.token_start = start_reg;
                r1.token_len   = len_reg;
            end
            mode_next  = cct_pkg::M_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            win_next   = '0;
            dig_next   = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            case (m)
                cct_pkg::M_IDENT:
                begin
                    absorbed = q_item.is_word;
                    emit_pend = !q_item.is_word;
                end
                cct_pkg::M_INT:
                begin
                    absorbed = q_item.is_digit || c == 8'h2e || c == 8'h65;
                    emit_pend = !absorbed;
                    if (c == 8'h2e)
                    begin
                        mode_next = cct_pkg::M_FRAC;
                        dig_next  = 1'b0;
                    end
                    else if (c == 8'h65)
                    begin
                        mode_next = cct_pkg::M_EXPSIGN;
                        dig_next  = 1'b0;
                    end
                end
                cct_pkg::M_FRAC,
                cct_pkg::M_EXP:
                begin
                    if (q_item.is_digit)
                    begin
                        absorbed = 1'b1;
                        dig_next = 1'b1;
                    end
                    else if (!dig_reg || (m == cct_pkg::M_FRAC && c == 8'h2e))
                    begin
                        if (q_item.is_space)
                        begin
                            emit_pend = 1'b1;
                            emit_kind = cct_pkg::K_INVALID;
                            absorbed  = 1'b1;
                            mode_next = cct_pkg::M_IDLE;
                        end
                        else
                        begin
                            absorbed  = 1'b1;
                            mode_next = cct_pkg::M_INVALID;
                        end
                    end
                    else if (m == cct_pkg::M_FRAC && c == 8'h65)
                    begin
                        absorbed  = 1'b1;
                        mode_next = cct_pkg::M_EXPSIGN;
                        dig_next  = 1'b0;
                    end
                    else if (c == 8'h66)
                    begin
                        absorbed  = 1'b1;
                        emit_pend = 1'b1;
                        emit_kind = cct_pkg::K_FLOAT;
                        mode_next = cct_pkg::M_IDLE;
                    end
                    else
                    begin
                        emit_pend = 1'b1;
                    end
                end
                cct_pkg::M_EXPSIGN:
                begin
                    absorbed = 1'b1;
                    if (c == 8'h2b || c == 8'h2d)
                    begin
                        mode_next = cct_pkg::M_EXP;
                        dig_next  = 1'b0;
                    end
                    else if (q_item.is_digit)
                    begin
                        mode_next = cct_pkg::M_EXP;
                        dig_next  = 1'b1;
                    end
                    else if (q_item.is_space)
                    begin
                        emit_pend = 1'b1;
                        emit_kind = cct_pkg::K_INVALID;
                        mode_next = cct_pkg::M_IDLE;
                    end
                    else
                    begin
                        mode_next = cct_pkg::M_INVALID;
                    end
                end
                cct_pkg::M_STRING:
                begin
                    absorbed = 1'b1;
                    if (c == 8'h22)
                    begin
                        emit_pend = 1'b1;
                        emit_kind = cct_pkg::K_STRING;
                        mode_next = cct_pkg::M_IDLE;
                    end
                    else if (c == 8'h5c)
                    begin
                        mode_next = cct_pkg::M_ESCAPE;
                    end
                end
                cct_pkg::M_ESCAPE:
                begin
                    absorbed  = 1'b1;
                    mode_next = cct_pkg::M_STRING;
                end
                cct_pkg::M_INVALID:
                begin
                    absorbed  = !q_item.is_space;
                    emit_pend = q_item.is_space;
                end
                default: ;
            endcase

            // A character taken into the token extends it, even when it ends it.
            if (absorbed && !(emit_pend && q_item.is_space && emit_kind == cct_pkg::K_INVALID
                && m != cct_pkg::M_INVALID))
            begin
                if (kw_slot)
                begin
                    win_next[{len_reg[cct_pkg::KW_IDX_BITS-1:0], 3'b000} +: 8] = c;
                end
                len_next = len_sat;
            end
            if (emit_pend)
            begin
                n1 = 1'b1;
                r1.token_kind  = emit_kind;
                r1.token_start = start_reg;
                r1.token_len   = len_next;
                if (!absorbed || q_item.is_space)
                begin
                    mode_next = cct_pkg::M_IDLE;
                end
            end

            if (!absorbed)
            begin
                mode_next = cct_pkg::M_IDLE;
                if (!q_item.is_space)
                begin
                    if (q_item.is_punct)
                    begin
                        n2 = 1'b1;
                        r2.token_kind  = cct_pkg::K_PUNCT0
                                         + cct_pkg::KIND_BITS'(q_item.punct_idx);
                        r2.token_start = pos_reg;
                        r2.token_len   = cct_pkg::LENGTH_BITS'(1);
                    end
                    else
                    begin
                        start_next = pos_reg;
                        len_next   = cct_pkg::LENGTH_BITS'(1);
                        win_next   = '0;
                        win_next[7:0] = c;
                        dig_next   = 1'b0;
                        if (c == 8'h22)
                        begin
                            mode_next = cct_pkg::M_STRING;
                        end
                        else if (q_item.is_alpha || c == 8'h5f)
                        begin
                            mode_next = cct_pkg::M_IDENT;
                        end
                        else if (q_item.is_digit)
                        begin
                            mode_next = cct_pkg::M_INT;
                        end
                        else
                        begin
                            mode_next = cct_pkg::M_INVALID;
                        end
                    end
                end
            end
        end

        if (n1 && n2)
        begin
            r2.last_in_run = 1'b1;
        end
        else if (n1)
        begin
            r1.last_in_run = 1'b1;
        end
        else
        begin
            r2.last_in_run = 1'b1;
        end
    end

    assign valid    = out_valid_reg;
    assign out_item = out_reg;

    always_ff @(posedge clk)
    begin
        if (take && (n1 || n2))
        begin
            out_reg <= n1 ? r1 : r2;
        end
        else if (pend_valid_reg && out_free)
        begin
            out_reg <= pend_reg;
        end
        if (take && n1 && n2)
        begin
            pend_reg <= r2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            mode_reg  <= cct_pkg::M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            win_reg   <= '0;
            dig_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                mode_reg  <= mode_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                len_reg   <= len_next;
                win_reg   <= win_next;
                dig_reg   <= dig_next;
                out_valid_reg  <= n1 || n2 || (out_valid_reg && stall);
                pend_valid_reg <= n1 && n2;
            end
            else if (out_free)
            begin
                out_valid_reg  <= pend_valid_reg;
                pend_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) pend_valid_reg |-> out_valid_reg)
        else $error("Second result pending with no first result shown.");
    assert property (@(posedge clk) disable iff (!rst_n) mode_reg <= cct_pkg::M_INVALID)
        else $error("Scan mode out of range.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (pend_valid_reg && out_free) |=> (out_valid_reg && !pend_valid_reg))
        else $error("Second result not moved forward.");

endmodule

/* rtl/c_subset_char_tokenizer_core.sv */
// Character tokeniser for a small subset of C. One character request is taken each cycle
// while the queue has room. A character that both closes a token and is a punctuator
// yields two results; the back end takes no more until the second leaves the pending slot.
// A two-entry queue sits between the classifying front end and the scanning back end.
module c_subset_char_tokenizer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  cct_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output cct_pkg::out_item_t out_data
);

    logic            q_valid;
    logic            q_stall;
    cct_pkg::class_t q_item;

    cct_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (in_valid),
        .stall   (in_stall),
        .in_item (in_data),
        .q_valid (q_valid),
        .q_stall (q_stall),
        .q_item  (q_item)
    );

    cct_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_stall  (q_stall),
        .q_item   (q_item),
        .valid    (out_valid),
        .stall    (out_stall),
        .out_item (out_data)
    );

endmodule
